/* sv/tcns_pkg.sv */
// Shared types and constants of the two-channel note sequencer.
`timescale 1ns / 1ps
`default_nettype none

package tcns_pkg;

  // Default sizes of the note store.
  localparam int CHANNELS_DEF     = 2;
  localparam int MAX_MEASURES_DEF = 64;
  localparam int MAX_NOTES_DEF    = 16;

  // Note entry: {length[5:0], rest, pitch[5:0]}.
  localparam int NOTE_W = 13;

  // Duration math: length * 3600 / tempo / 8, saturated to 8 bits.
  localparam int         NUM_W          = 18;
  localparam logic [11:0] FRAMES_PER_MIN = 12'd3600;
  localparam int         QUARTER_SHIFT  = 3;   // quarter note is 8 thirty-seconds
  localparam logic [7:0] SAT8           = 8'hFF;

  // Register reset values.
  localparam logic [7:0] TEMPO_RST       = 8'd120;
  localparam logic [5:0] FIRST_LEN_RST   = 6'd32;
  localparam logic [5:0] MEAS_LEN_RST    = 6'd32;
  localparam logic [6:0] MEAS_TOTAL_RST  = 7'd1;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    REG_TEMPO      = 2'd0,
    REG_FIRST_LEN  = 2'd1,
    REG_MEAS_LEN   = 2'd2,
    REG_MEAS_TOTAL = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    op_e        op;
    logic       load_channel;
    logic [5:0] load_measure;
    logic [3:0] load_slot;
    logic [5:0] load_pitch;
    logic       load_rest;
    logic [5:0] load_length;
  } in_word_t;

  typedef struct packed {
    logic       out_channel;
    logic [5:0] out_pitch;
    logic       out_rest;
    logic [5:0] out_measure;
    logic       new_measure;
    logic       last;
  } out_word_t;

  typedef struct packed {
    cfg_reg_e   addr;
    logic [7:0] data;
  } cfg_word_t;

endpackage

`default_nettype wire

/* sv/tcns_stream_if.sv */
// Valid/ready channel carrying one word of a given type.
`timescale 1ns / 1ps
`default_nettype none

interface tcns_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* sv/two_channel_note_sequencer_unit.sv */
// Top level of the two-channel measure-synchronized note sequencer.
// Channels: in_if (sink) takes load and tick words, cfg_if (sink) writes the
// tempo and measure registers, out_if (source) gives one word per note start.
// A load word is taken and written straight into the note RAM;
// ready stays high, so loads can follow back to back.
// A tick word walks the channels one by one:
// per channel a check state, and for a channel that starts a note a RAM
// read state, a wait on the shared serial divider (duration in frames)
// and an emit state that places the word in the output register.
// in_if.ready is high only while no tick is in work.
// The output word sits in a register; when the receiver stalls, the walk
// waits in front of that register and words are never dropped or repeated.
// The last word of a tick carries last = 1; a tick with no starts gives none.
// Reset clears the sequencing state and loads register defaults (tempo 120,
// measure lengths 32, one measure). The note RAM is not cleared: a note must
// be loaded before a tick plays it. cfg_if is always ready; write registers
// only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module two_channel_note_sequencer_unit #(
  parameter int CHANNELS     = tcns_pkg::CHANNELS_DEF,
  parameter int MAX_MEASURES = tcns_pkg::MAX_MEASURES_DEF,
  parameter int MAX_NOTES    = tcns_pkg::MAX_NOTES_DEF
) (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  tcns_stream_if.sink   in_if,
  tcns_stream_if.sink   cfg_if,
  tcns_stream_if.source out_if
);

  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int MSR_W  = (MAX_MEASURES > 1) ? $clog2(MAX_MEASURES) : 1;
  localparam int NT_W   = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
  localparam int DEPTH  = CHANNELS * MAX_MEASURES * MAX_NOTES;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NOTE_W = tcns_pkg::NOTE_W;
  localparam int NUM_W  = tcns_pkg::NUM_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_READ,
    S_DIV,
    S_EMIT
  } state_e;

  // Register file
  logic [7:0] tempo_q;
  logic [5:0] first_len_q;
  logic [5:0] meas_len_q;
  logic [6:0] meas_total_q;

  // Sequencing state
  state_e              state_q;
  logic [MSR_W-1:0]    measure_q;
  logic                not_started_q;
  logic [NT_W-1:0]     pos_q    [CHANNELS];
  logic [7:0]          frames_q [CHANNELS];
  logic [7:0]          lsf_q    [CHANNELS];  // length played so far
  logic [CH_W-1:0]     ch_q;
  logic                all_done_q;
  logic [5:0]          cur_len_q;
  logic [NT_W-1:0]     slot_q;
  logic [NOTE_W-1:0]   note_q;
  logic                out_valid_q;
  tcns_pkg::out_word_t out_q;

  // Combinational helpers
  logic              in_acc, tick_go, load_go, load_in_range;
  logic [5:0]        cur_len;
  logic              all_done;
  logic [8:0]        next_meas;
  logic [MSR_W-1:0]  meas_new;
  logic              start_ch;
  logic [NT_W-1:0]   slot_sel;
  logic              more_after;
  logic              ch_last;
  logic              emit_go;
  logic [5:0]        note_len;
  logic [8:0]        lsf_sum;
  logic [7:0]        lsf_new;
  logic [MSR_W+5:0]  meas_ext;
  logic [AW-1:0]     waddr, raddr;
  logic [NOTE_W-1:0] rdata;
  logic              ram_re;
  logic              div_start, div_busy, div_done;
  logic [NUM_W-1:0]  div_num;
  logic [7:0]        div_frames;

  function automatic logic [AW-1:0] note_addr(input logic [31:0] c,
                                               input logic [31:0] m,
                                               input logic [31:0] s);
    logic [31:0] a;
    a = (c * 32'(MAX_MEASURES) + m) * 32'(MAX_NOTES) + s;
    note_addr = a[AW-1:0];
  endfunction

  assign in_if.ready  = (state_q == S_IDLE);
  assign cfg_if.ready = 1'b1;
  assign in_acc       = in_if.valid && in_if.ready;
  assign tick_go      = in_acc && (in_if.data.op == tcns_pkg::OP_TICK);
  assign load_in_range = (32'(in_if.data.load_channel) < 32'(CHANNELS)) &&
                         (32'(in_if.data.load_measure) < 32'(MAX_MEASURES)) &&
                         (32'(in_if.data.load_slot) < 32'(MAX_NOTES));
  assign load_go      = in_acc && (in_if.data.op == tcns_pkg::OP_LOAD) && load_in_range;

  // Measure length and end-of-measure test, on the state before the tick.
  always_comb begin
    cur_len  = (!not_started_q && (measure_q == '0)) ? first_len_q : meas_len_q;
    all_done = 1'b1;
    for (int c = 0; c < CHANNELS; c++) begin
      if ((frames_q[c] != 8'd0) || (lsf_q[c] < {2'b00, cur_len})) begin
        all_done = 1'b0;
      end
    end
    next_meas = not_started_q ? 9'd0 : (9'(measure_q) + 9'd1);
    if ((next_meas >= 9'(meas_total_q)) || (next_meas >= 9'(MAX_MEASURES))) begin
      next_meas = 9'd0;
    end
    meas_new = next_meas[MSR_W-1:0];
  end

  // Per-channel decision during the walk.
  always_comb begin
    start_ch = all_done_q ||
               ((frames_q[ch_q] == 8'd0) && (lsf_q[ch_q] < {2'b00, cur_len_q}));
    if (all_done_q) begin
      slot_sel = '0;
    end else if (pos_q[ch_q] == NT_W'(MAX_NOTES - 1)) begin
      slot_sel = '0;
    end else begin
      slot_sel = pos_q[ch_q] + NT_W'(1);
    end
    // Does a later channel start a note in this tick?
    more_after = 1'b0;
    for (int c = 0; c < CHANNELS; c++) begin
      if ((c > int'(ch_q)) &&
          (all_done_q || ((frames_q[c] == 8'd0) && (lsf_q[c] < {2'b00, cur_len_q})))) begin
        more_after = 1'b1;
      end
    end
  end

  assign ch_last  = (ch_q == CH_W'(CHANNELS - 1));
  assign emit_go  = (state_q == S_EMIT) && (!out_valid_q || out_if.ready);
  assign note_len = note_q[12:7];
  assign lsf_sum  = {1'b0, lsf_q[ch_q]} + {3'b000, note_len};
  assign lsf_new  = lsf_sum[8] ? tcns_pkg::SAT8 : lsf_sum[7:0];
  assign meas_ext = {6'b000000, measure_q};

  // Note RAM
  assign waddr  = note_addr(32'(in_if.data.load_channel), 32'(in_if.data.load_measure),
                            32'(in_if.data.load_slot));
  assign raddr  = note_addr(32'(ch_q), 32'(measure_q), 32'(slot_sel));
  assign ram_re = (state_q == S_CHECK) && start_ch;

  tcns_ram #(
    .WIDTH (NOTE_W),
    .DEPTH (DEPTH)
  ) u_note_ram (
    .clk_i   (clk_i),
    .we_i    (load_go),
    .waddr_i (waddr),
    .wdata_i ({in_if.data.load_length, in_if.data.load_rest, in_if.data.load_pitch}),
    .re_i    (ram_re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Shared duration divider
  assign div_start = (state_q == S_READ);
  assign div_num   = NUM_W'(rdata[12:7]) * NUM_W'(tcns_pkg::FRAMES_PER_MIN);

  tcns_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_i    (div_num),
    .den_i    (tempo_q),
    .busy_o   (div_busy),
    .done_o   (div_done),
    .frames_o (div_frames)
  );

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tempo_q      <= tcns_pkg::TEMPO_RST;
      first_len_q  <= tcns_pkg::FIRST_LEN_RST;
      meas_len_q   <= tcns_pkg::MEAS_LEN_RST;
      meas_total_q <= tcns_pkg::MEAS_TOTAL_RST;
    end else if (cfg_if.valid && cfg_if.ready) begin
      case (cfg_if.data.addr)
        tcns_pkg::REG_TEMPO:      tempo_q      <= cfg_if.data.data;
        tcns_pkg::REG_FIRST_LEN:  first_len_q  <= cfg_if.data.data[5:0];
        tcns_pkg::REG_MEAS_LEN:   meas_len_q   <= cfg_if.data.data[5:0];
        tcns_pkg::REG_MEAS_TOTAL: meas_total_q <= cfg_if.data.data[6:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      measure_q     <= '0;
      not_started_q <= 1'b1;
      ch_q          <= '0;
      all_done_q    <= 1'b0;
      cur_len_q     <= '0;
      slot_q        <= '0;
      note_q        <= '0;
      out_valid_q   <= 1'b0;
      out_q         <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        pos_q[c]    <= '0;
        frames_q[c] <= '0;
        lsf_q[c]    <= tcns_pkg::SAT8;
      end
    end else begin
      // output register: loaded on emit, emptied when the receiver takes it
      if (emit_go) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (tick_go) begin
            all_done_q <= all_done;
            cur_len_q  <= cur_len;
            ch_q       <= '0;
            if (all_done) begin
              measure_q     <= meas_new;
              not_started_q <= 1'b0;
            end
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (start_ch) begin
            slot_q  <= slot_sel;
            state_q <= S_READ;
          end else begin
            if (frames_q[ch_q] != 8'd0) begin
              frames_q[ch_q] <= frames_q[ch_q] - 8'd1;
            end
            if (ch_last) begin
              state_q <= S_IDLE;
            end else begin
              ch_q <= ch_q + CH_W'(1);
            end
          end
        end
        S_READ: begin
          note_q  <= rdata;
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            out_q.out_channel <= ch_q[0];
            out_q.out_pitch   <= note_q[5:0];
            out_q.out_rest    <= note_q[6];
            out_q.out_measure <= meas_ext[5:0];
            out_q.new_measure <= all_done_q;
            out_q.last        <= !more_after;
            pos_q[ch_q]       <= slot_q;
            lsf_q[ch_q]       <= all_done_q ? {2'b00, note_len} : lsf_new;
            frames_q[ch_q]    <= div_frames;
            if (ch_last) begin
              state_q <= S_IDLE;
            end else begin
              ch_q    <= ch_q + CH_W'(1);
              state_q <= S_CHECK;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_q;

`ifndef SYNTHESIS
  // The divider is only started when it is free.
  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  // The channel walk never runs past the last channel.
  a_ch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (32'(ch_q) < 32'(CHANNELS)))
    else $error("channel index out of range");

  // The last channel's word closes the tick: the sequencer is idle right after.
  a_last_ends_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_go && ch_last) |=> (state_q == S_IDLE))
    else $error("last channel placed but tick still in work");

  // Divider result arrives only while waiting for it.
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside the wait state");
`endif

endmodule

`default_nettype wire

/* sv/tcns_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module tcns_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 2048
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                      wdata_i,
  input  wire logic                                  re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* sv/tcns_div.sv */
// Bit-serial divider giving a note duration in frames, saturated to 8 bits.
`timescale 1ns / 1ps
`default_nettype none

module tcns_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [tcns_pkg::NUM_W-1:0] num_i,
  input  wire logic [7:0]                 den_i,
  output logic                            busy_o,
  output logic                            done_o,
  output logic [7:0]                      frames_o
);

  localparam int NUM_W = tcns_pkg::NUM_W;
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [7:0]       rem_q, rem_d;
  logic [NUM_W-1:0] sh_q, sh_d;
  logic [7:0]       den_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [8:0]       trial;
  logic             ge;
  logic [NUM_W-1:0] quo_scaled;

  // One restoring step per cycle: numerator bits shift out, quotient bits shift in.
  always_comb begin
    trial = {rem_q, sh_q[NUM_W-1]};
    ge    = (trial >= {1'b0, den_q});
    rem_d = ge ? 8'(trial - {1'b0, den_q}) : trial[7:0];
    sh_d  = {sh_q[NUM_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      sh_q   <= '0;
      den_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_W'(NUM_W - 1));
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rem_q  <= '0;
        sh_q   <= num_i;
        den_q  <= den_i;
      end else if (busy_q) begin
        rem_q <= rem_d;
        sh_q  <= sh_d;
        if (cnt_q == CNT_W'(NUM_W - 1)) begin
          busy_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q + CNT_W'(1);
        end
      end
    end
  end

  assign quo_scaled = sh_q >> tcns_pkg::QUARTER_SHIFT;
  assign frames_o   = ((den_q == 8'd0) || (|quo_scaled[NUM_W-1:8])) ?
                      tcns_pkg::SAT8 : quo_scaled[7:0];
  assign busy_o     = busy_q;
  assign done_o     = done_q;

endmodule

`default_nettype wire

/* dv/tb_two_channel_note_sequencer_unit.sv */
// Self-checking testbench of the two-channel note sequencer: note loads, frame ticks, registers.
`timescale 1ns / 1ps

module tb_two_channel_note_sequencer_unit;
  import tcns_pkg::*;

  // Store geometry and timing of the run.
  localparam int CH           = CHANNELS_DEF;
  localparam int MEASURES     = MAX_MEASURES_DEF;
  localparam int NOTES        = MAX_NOTES_DEF;
  localparam int NOTE_QUARTER = 1 << QUARTER_SHIFT;
  localparam int SETTLE_CYC   = 60;
  localparam int PHASE_WORDS  = 150;
  localparam int TIMEOUT_NS   = 30_000_000;  // far above a slow clean run

  logic clk_i = 1'b0;
  logic rst_ni;

  tcns_stream_if #(.T(in_word_t))  in_if ();
  tcns_stream_if #(.T(cfg_word_t)) cfg_if ();
  tcns_stream_if #(.T(out_word_t)) out_if ();

  two_channel_note_sequencer_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .cfg_if (cfg_if),
    .out_if (out_if)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Sequencer mirror: register copies, note RAM with a written map, and the
  // per-channel play state. Updated once per accepted word, in order.
  // ---------------------------------------------------------------------------
  logic [7:0]  tempo_r      = TEMPO_RST;
  logic [5:0]  first_len_r  = FIRST_LEN_RST;
  logic [5:0]  meas_len_r   = MEAS_LEN_RST;
  logic [6:0]  meas_total_r = MEAS_TOTAL_RST;

  logic [NOTE_W-1:0] note_ram   [CH][MEASURES][NOTES];
  bit                note_valid [CH][MEASURES][NOTES];

  logic [5:0] meas_now     = '0;
  logic       before_first = 1'b1;
  logic [3:0] slot_pos     [CH];
  logic [7:0] frames_left  [CH];
  logic [7:0] len_sum      [CH];

  out_word_t pending_starts[$];   // note starts still owed by the block

  int words_sent   = 0;
  int mismatch_cnt = 0;
  bit calm         = 1'b0;        // no idling on either side while set
  int hold_left    = 0;

  initial begin
    for (int c = 0; c < CH; c++) begin
      slot_pos[c]    = '0;
      frames_left[c] = '0;
      len_sum[c]     = SAT8;
    end
  end

  // Frames a note of the given length lasts at the current tempo.
  function automatic logic [7:0] note_frames(logic [5:0] len);
    int f;
    if (tempo_r == 8'd0) return SAT8;
    f = int'(len) * int'(FRAMES_PER_MIN) / int'(tempo_r) / NOTE_QUARTER;
    return (f > 255) ? SAT8 : 8'(f);
  endfunction

  // Measure 0 has its own length, but only once play has begun.
  function automatic int cur_measure_len();
    return (!before_first && meas_now == 6'd0) ? int'(first_len_r) : int'(meas_len_r);
  endfunction

  function automatic bit measure_over(int cur);
    bit over;
    over = 1'b1;
    for (int c = 0; c < CH; c++)
      if (frames_left[c] != 8'd0 || int'(len_sum[c]) < cur) over = 1'b0;
    return over;
  endfunction

  function automatic logic [5:0] next_measure();
    int nxt;
    nxt = before_first ? 0 : int'(meas_now) + 1;
    if (nxt >= int'(meas_total_r) || nxt >= MEASURES) nxt = 0;
    return 6'(nxt);
  endfunction

  function automatic out_word_t start_word(int c, logic [5:0] p, logic r, logic [5:0] m,
                                           logic nm, logic lst);
    out_word_t o;
    o.out_channel = 1'(c);
    o.out_pitch   = p;
    o.out_rest    = r;
    o.out_measure = m;
    o.new_measure = nm;
    o.last        = lst;
    return o;
  endfunction

  // Next tick would read a note nobody loaded: report its address.
  function automatic bit find_unloaded(output logic ch, output logic [5:0] m,
                                       output logic [3:0] s);
    int         cur;
    logic [5:0] nm;
    logic [3:0] sl;
    cur = cur_measure_len();
    if (measure_over(cur)) begin
      nm = next_measure();
      for (int c = 0; c < CH; c++)
        if (!note_valid[c][nm][0]) begin
          ch = 1'(c); m = nm; s = 4'd0;
          return 1'b1;
        end
      return 1'b0;
    end
    for (int c = 0; c < CH; c++) begin
      sl = slot_pos[c] + 4'd1;
      if (frames_left[c] == 8'd0 && int'(len_sum[c]) < cur && !note_valid[c][meas_now][sl]) begin
        ch = 1'(c); m = meas_now; s = sl;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Applies one accepted word; queues the note starts it causes when keep is set.
  function automatic void predict_note_starts(in_word_t w, bit keep);
    out_word_t   starts [CH];
    out_word_t   wd;
    int          k;
    int          cur;
    int          sum;
    logic [12:0] n;
    logic [3:0]  sl;
    k = 0;
    if (w.op == OP_LOAD) begin
      note_ram[w.load_channel][w.load_measure][w.load_slot] =
        {w.load_length, w.load_rest, w.load_pitch};
      note_valid[w.load_channel][w.load_measure][w.load_slot] = 1'b1;
      return;
    end
    cur = cur_measure_len();
    if (measure_over(cur)) begin
      // every channel finished: all restart at slot 0 of the next measure
      meas_now     = next_measure();
      before_first = 1'b0;
      for (int c = 0; c < CH; c++) begin
        n              = note_ram[c][meas_now][0];
        slot_pos[c]    = 4'd0;
        len_sum[c]     = {2'b00, n[12:7]};
        frames_left[c] = note_frames(n[12:7]);
        starts[k]      = start_word(c, n[5:0], n[6], meas_now, 1'b1, 1'b0);
        k++;
      end
    end else begin
      for (int c = 0; c < CH; c++) begin
        if (frames_left[c] != 8'd0) begin
          frames_left[c]--;
        end else if (int'(len_sum[c]) < cur) begin
          sl             = slot_pos[c] + 4'd1;   // slot wraps at 16
          slot_pos[c]    = sl;
          n              = note_ram[c][meas_now][sl];
          sum            = int'(len_sum[c]) + int'(n[12:7]);
          len_sum[c]     = (sum > 255) ? SAT8 : 8'(sum);
          frames_left[c] = note_frames(n[12:7]);
          starts[k]      = start_word(c, n[5:0], n[6], meas_now, 1'b0, 1'b0);
          k++;
        end
      end
    end
    for (int i = 0; i < k; i++) begin
      wd      = starts[i];
      wd.last = (i == k - 1);
      if (keep) pending_starts.push_back(wd);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Word builders and handshakes
  // ---------------------------------------------------------------------------
  function automatic in_word_t load_word(int ch, int m, int s, int p, int r, int len);
    in_word_t w;
    w.op           = OP_LOAD;
    w.load_channel = 1'(ch);
    w.load_measure = 6'(m);
    w.load_slot    = 4'(s);
    w.load_pitch   = 6'(p);
    w.load_rest    = 1'(r);
    w.load_length  = 6'(len);
    return w;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int pick_len(int len_max);
    return ($urandom_range(0, 9) == 0) ? $urandom_range(1, 32) : $urandom_range(1, len_max);
  endfunction

  // valid stays high from one word to the next unless a gap is drawn
  task automatic send_word(in_word_t w);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.data  = w;
    in_if.valid = 1'b1;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    words_sent++;
  endtask

  task automatic send_and_predict(in_word_t w);
    send_word(w);
    predict_note_starts(w, 1'b1);
  endtask

  // Load whatever the tick is about to read, then send the tick itself
  // with junk in the load fields.
  task automatic issue_tick(int len_max);
    logic       ch;
    logic [5:0] m;
    logic [3:0] s;
    in_word_t   w;
    while (find_unloaded(ch, m, s))
      send_and_predict(load_word(ch, m, s, $urandom_range(0, 63), $urandom_range(0, 1),
                                 pick_len(len_max)));
    w    = load_word($urandom_range(0, 1), $urandom_range(0, 63), $urandom_range(0, 15),
                     $urandom_range(0, 63), $urandom_range(0, 1), $urandom_range(0, 63));
    w.op = OP_TICK;
    send_and_predict(w);
  endtask

  // Idle the sender until every owed start is back, plus some settle time.
  task automatic drain(int extra);
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (pending_starts.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e a, int val);
    @(negedge clk_i);
    cfg_if.data  = '{addr: a, data: 8'(val)};
    cfg_if.valid = 1'b1;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    case (a)
      REG_TEMPO:      tempo_r      = 8'(val);
      REG_FIRST_LEN:  first_len_r  = 6'(val);
      REG_MEAS_LEN:   meas_len_r   = 6'(val);
      REG_MEAS_TOTAL: meas_total_r = 7'(val);
      default: ;
    endcase
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure, and the scoreboard on accepted words
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_if.ready = 1'b0;
      hold_left--;
    end else begin
      out_if.ready = 1'b1;
      if ($urandom_range(0, 3) == 0) hold_left = pick_gap();
    end
  end

  task automatic flag_mismatch(string what, out_word_t e, out_word_t g);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      $display("%0t %s: exp ch=%0d pitch=%0d rest=%0d meas=%0d new=%0d last=%0d",
               $realtime, what, e.out_channel, e.out_pitch, e.out_rest, e.out_measure,
               e.new_measure, e.last);
      $display("    got ch=%0d pitch=%0d rest=%0d meas=%0d new=%0d last=%0d",
               g.out_channel, g.out_pitch, g.out_rest, g.out_measure, g.new_measure,
               g.last);
    end
  endtask

  always @(posedge clk_i) begin
    out_word_t got;
    out_word_t want;
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      got = out_if.data;
      if (pending_starts.size() == 0) begin
        flag_mismatch("unexpected note start", '0, got);
      end else begin
        want = pending_starts.pop_front();
        if (got.out_channel !== want.out_channel || got.out_pitch   !== want.out_pitch ||
            got.out_rest    !== want.out_rest    || got.out_measure !== want.out_measure ||
            got.new_measure !== want.new_measure || got.last        !== want.last)
          flag_mismatch("note start differs", want, got);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Directed table: word, and where the outcome is obvious, the typed-in starts.
  // Untyped rows fall back to the mirror.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    in_word_t   w;
    logic       typed;
    logic [1:0] n;
    out_word_t  e0;
    out_word_t  e1;
  } dir_row_t;

  dir_row_t dir_tab[$];

  task automatic add_row(in_word_t w, bit typed, int n = 0,
                         out_word_t e0 = '0, out_word_t e1 = '0);
    dir_tab.push_back('{w: w, typed: typed, n: 2'(n), e0: e0, e1: e1});
  endtask

  // Hard stop in case the block hangs.
  initial begin
    #(TIMEOUT_NS);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    in_word_t tick_ones;
    int       phase_no;
    int       phase_end;
    int       r;
    int       len_max;
    int       tempo_v;
    int       first_v;
    int       mlen_v;
    int       total_v;

    rst_ni       = 1'b0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    out_if.ready = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    tick_ones    = '1;
    tick_ones.op = OP_TICK;

    // Reset registers: tempo 120, lengths 32, one measure.
    // Loads at the corners of every field; none gives a start.
    add_row(load_word(0, 0, 0, 63, 0, 32), 1'b1);
    add_row(load_word(1, 0, 0, 0, 1, 1), 1'b1);
    add_row(load_word(1, 0, 1, 42, 0, 31), 1'b1);
    add_row(load_word(0, 0, 1, 21, 1, 16), 1'b1);
    add_row(load_word(1, 63, 15, 33, 1, 8), 1'b1);
    add_row(load_word(0, 63, 15, 12, 0, 32), 1'b1);
    // First tick opens measure 0 on both channels; ch1's note is a rest.
    add_row(load_word(0, 0, 0, 0, 0, 0) | tick_ones & '0 | in_word_t'({OP_TICK, 24'd0}),
            1'b1, 2,
            start_word(0, 6'd63, 1'b0, 6'd0, 1'b1, 1'b0),
            start_word(1, 6'd0, 1'b1, 6'd0, 1'b1, 1'b1));
    // Tick with every load field set: fields must be ignored.
    add_row(tick_ones, 1'b0);
    // Overwrite a note before it is played.
    add_row(load_word(1, 0, 1, 17, 1, 31), 1'b0);
    add_row(tick_ones, 1'b0);
    add_row(tick_ones, 1'b0);
    add_row(tick_ones, 1'b0);   // ch1 moves to its second note here
    add_row(tick_ones, 1'b0);
    add_row(load_word(0, 1, 0, 5, 0, 4), 1'b0);
    add_row(tick_ones, 1'b0);

    foreach (dir_tab[i]) begin
      send_word(dir_tab[i].w);
      predict_note_starts(dir_tab[i].w, !dir_tab[i].typed);
      if (dir_tab[i].typed) begin
        if (dir_tab[i].n > 0) pending_starts.push_back(dir_tab[i].e0);
        if (dir_tab[i].n > 1) pending_starts.push_back(dir_tab[i].e1);
      end
    end

    // Random phases. Each one settles, rewrites all four registers, then
    // plays mostly ticks with on-demand note loads, plus stray loads.
    phase_no = 1;
    while (phase_no < 9 || words_sent < 1500) begin
      drain(SETTLE_CYC);
      case (phase_no)
        1: begin  // fastest tempo, one-32nd measures, walk all 64 measures
          tempo_v = 255; first_v = 1;  mlen_v = 1;  total_v = 64; len_max = 1;
        end
        2: begin  // slowest tempo: durations saturate
          tempo_v = 1;   first_v = 32; mlen_v = 32; total_v = 1;  len_max = 32;
        end
        3: begin  // short notes fill long measures: slot index wraps
          tempo_v = 255; first_v = 32; mlen_v = 32; total_v = 3;  len_max = 1;
        end
        default: begin
          tempo_v = ($urandom_range(0, 1) == 0) ? $urandom_range(160, 255)
                                                 : $urandom_range(1, 255);
          first_v = $urandom_range(1, 32);
          mlen_v  = $urandom_range(1, 32);
          total_v = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 4) : $urandom_range(1, 64);
          case ($urandom_range(0, 4))
            0:       len_max = 1;
            1:       len_max = 2;
            2:       len_max = 4;
            3:       len_max = 8;
            default: len_max = 32;
          endcase
        end
      endcase
      write_reg(REG_TEMPO, tempo_v);
      write_reg(REG_FIRST_LEN, first_v);
      write_reg(REG_MEAS_LEN, mlen_v);
      write_reg(REG_MEAS_TOTAL, total_v);
      calm = ($urandom_range(0, 4) == 0);

      phase_end = words_sent + PHASE_WORDS;
      while (words_sent < phase_end) begin
        r = $urandom_range(0, 99);
        if (r < 2)
          drain(0);
        else if (r < 75)
          issue_tick(len_max);
        else if (r < 88)
          send_and_predict(load_word($urandom_range(0, 1), $urandom_range(0, 63),
                                     $urandom_range(0, 15), $urandom_range(0, 63),
                                     $urandom_range(0, 1), pick_len(len_max)));
        else  // rewrite a note of the measure in play
          send_and_predict(load_word($urandom_range(0, 1), meas_now, $urandom_range(0, 15),
                                     $urandom_range(0, 63), $urandom_range(0, 1),
                                     pick_len(len_max)));
      end
      phase_no++;
    end

    drain(SETTLE_CYC);
    while (pending_starts.size() != 0) begin
      flag_mismatch("note start never arrived", pending_starts.pop_front(), '0);
    end
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
